// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk while rst_n is high.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a property in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: rtl/bacs_pkg.sv
// ----------------------------------------------------------------------------
// bacs_pkg
// Types shared by the front end, the result queue and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bacs_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    // One destination byte with its write mask.
    typedef struct packed {
        logic [7:0] dst_byte;
        logic [7:0] write_mask;
        logic       last;
    } result_t;

    // Results caused by one source byte: one or two.
    typedef struct packed {
        result_t res0;
        result_t res1;
        logic    two;
    } item_t;

endpackage

`default_nettype wire

// File: rtl/bacs_front.sv
// ----------------------------------------------------------------------------
// bacs_front
// Configuration registers, transfer state and realignment of source bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bacs_front #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bacs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [LENGTH_BITS-1:0]         cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     src_byte,
    input  logic                           q_full,
    output logic                           push,
    output bacs_pkg::item_t                push_item
);
    import bacs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_OFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_OFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN     = 2'd2;

    logic [2:0]             src_off_reg, src_off_next;
    logic [2:0]             dst_off_reg, dst_off_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [7:0]             carry_reg, carry_next;
    logic [3:0]             carry_cnt_reg, carry_cnt_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic                   first_reg, first_next;

    logic                   arm;
    logic                   in_fire;
    logic                   active;
    logic [2:0]             skip;
    logic [3:0]             avail;
    logic [3:0]             n;
    logic [7:0]             shifted;
    logic [7:0]             val;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic [14:0]            acc;
    logic [14:0]            acc2;
    logic [3:0]             cnt;
    logic [3:0]             cnt2;
    logic                   emit0;
    logic                   flush;
    logic                   first1;
    logic [2:0]             start0;
    logic [2:0]             start1;
    logic [7:0]             byte0;
    logic [7:0]             byte1;
    logic [7:0]             mask0;
    logic [7:0]             mask1;
    result_t                r0;
    result_t                r1;

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;
    assign active   = (rem_reg != '0);

    always_comb
    begin
        skip    = (rem_reg == len_reg) ? src_off_reg : 3'd0;
        avail   = 4'd8 - {1'b0, skip};
        if (rem_reg < LENGTH_BITS'(avail))
        begin
            n = rem_reg[3:0];
        end
        else
        begin
            n = avail;
        end
        shifted = 8'(src_byte << skip);
        val     = shifted >> (4'd8 - n);
        rem_dec = rem_reg - LENGTH_BITS'(n);
        acc     = ({7'd0, carry_reg} << n) | {7'd0, val};
        cnt     = carry_cnt_reg + n;

        // Full destination byte once eight bits are pending.
        emit0 = cnt[3];
        if (emit0)
        begin
            byte0 = 8'(acc >> (cnt - 4'd8));
            cnt2  = cnt - 4'd8;
            acc2  = acc & ((15'd1 << cnt2) - 15'd1);
        end
        else
        begin
            byte0 = '0;
            cnt2  = cnt;
            acc2  = acc;
        end
        start0 = first_reg ? dst_off_reg : 3'd0;
        mask0  = 8'hFF >> start0;

        // Drain the tail as a left-aligned partial byte.
        flush  = (rem_dec == '0) && (cnt2 != 4'd0);
        first1 = first_reg && !emit0;
        start1 = first1 ? dst_off_reg : 3'd0;
        byte1  = 8'(acc2 << (4'd8 - cnt2));
        mask1  = (8'hFF >> start1) & 8'(8'hFF << (4'd8 - cnt2));

        r0.dst_byte   = byte0 & mask0;
        r0.write_mask = mask0;
        r0.last       = (rem_dec == '0) && (cnt2 == 4'd0);
        r1.dst_byte   = byte1 & mask1;
        r1.write_mask = mask1;
        r1.last       = 1'b1;

        if (emit0)
        begin
            push_item.res0 = r0;
            push_item.res1 = r1;
            push_item.two  = flush;
        end
        else
        begin
            push_item.res0 = r1;
            push_item.res1 = r1;
            push_item.two  = 1'b0;
        end
        push = in_fire && active && (emit0 || flush);
    end

    always_comb
    begin
        src_off_next   = src_off_reg;
        dst_off_next   = dst_off_reg;
        len_next       = len_reg;
        carry_next     = carry_reg;
        carry_cnt_next = carry_cnt_reg;
        rem_next       = rem_reg;
        first_next     = first_reg;
        arm            = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC_OFF:
                begin
                    src_off_next = cfg_data[2:0];
                    arm          = 1'b1;
                end
                CFG_DST_OFF:
                begin
                    dst_off_next = cfg_data[2:0];
                    arm          = 1'b1;
                end
                CFG_LEN:
                begin
                    len_next = cfg_data;
                    arm      = 1'b1;
                end
                default:
                begin
                    arm = 1'b0;
                end
            endcase
        end
        if (arm)
        begin
            // Start a new transfer; drop anything pending.
            carry_next     = '0;
            carry_cnt_next = {1'b0, dst_off_next};
            rem_next       = len_next;
            first_next     = 1'b1;
        end
        else if (in_fire && active)
        begin
            rem_next       = rem_dec;
            carry_next     = flush ? 8'd0 : acc2[7:0];
            carry_cnt_next = flush ? 4'd0 : cnt2;
            first_next     = first_reg && !emit0 && !flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_off_reg   <= '0;
            dst_off_reg   <= '0;
            len_reg       <= '0;
            carry_reg     <= '0;
            carry_cnt_reg <= '0;
            rem_reg       <= '0;
            first_reg     <= 1'b1;
        end
        else
        begin
            src_off_reg   <= src_off_next;
            dst_off_reg   <= dst_off_next;
            len_reg       <= len_next;
            carry_reg     <= carry_next;
            carry_cnt_reg <= carry_cnt_next;
            rem_reg       <= rem_next;
            first_reg     <= first_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bacs_queue.sv
// ----------------------------------------------------------------------------
// bacs_queue
// Short FIFO of result groups between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bacs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bacs_pkg::item_t push_item,
    input  logic            pop,
    output bacs_pkg::item_t head_item,
    output logic            full,
    output logic            empty
);
    import bacs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (cnt_reg == '0);
    assign head_item = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bacs_back.sv
// ----------------------------------------------------------------------------
// bacs_back
// Output register that hands out queued results one per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bacs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  bacs_pkg::item_t head_item,
    input  logic            empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      dst_byte,
    output logic [7:0]      write_mask,
    output logic            last
);
    import bacs_pkg::*;

    logic    out_vld_reg, out_vld_next;
    result_t out_res_reg, out_res_next;
    logic    sec_vld_reg, sec_vld_next;
    result_t sec_res_reg, sec_res_next;
    logic    load;

    assign load = !out_vld_reg || out_ready;
    assign pop  = load && !sec_vld_reg && !empty;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_res_next = out_res_reg;
        sec_vld_next = sec_vld_reg;
        sec_res_next = sec_res_reg;
        if (load)
        begin
            if (sec_vld_reg)
            begin
                // Second result of the previous group goes out first.
                out_vld_next = 1'b1;
                out_res_next = sec_res_reg;
                sec_vld_next = 1'b0;
            end
            else if (!empty)
            begin
                out_vld_next = 1'b1;
                out_res_next = head_item.res0;
                sec_vld_next = head_item.two;
                sec_res_next = head_item.res1;
            end
            else
            begin
                out_vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            sec_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            sec_vld_reg <= sec_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
        sec_res_reg <= sec_res_next;
    end

    assign out_valid  = out_vld_reg;
    assign dst_byte   = out_res_reg.dst_byte;
    assign write_mask = out_res_reg.write_mask;
    assign last       = out_res_reg.last;

endmodule

`default_nettype wire

// File: rtl/bit_aligned_copy_shifter.sv
// ----------------------------------------------------------------------------
// bit_aligned_copy_shifter
// Bit-granular copy engine: realigns a source byte stream to a destination
// bit offset and emits masked destination bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Write src_bit_offset (index 0), dst_bit_offset (index 1) and bit_length
//   (index 2) on the cfg port while idle; each write arms a new transfer.
//   Then stream source bytes on in_valid/in_ready, first byte first. Each
//   accepted byte yields zero, one or two destination bytes on
//   out_valid/out_ready with write_mask and last; last marks the final byte.
//   Bytes beyond the copied span, or with a zero length, are taken and
//   dropped.
//   Results of an accepted byte pass through the result queue and then the
//   output register. Throughput: one source byte per cycle; a byte that
//   yields two results holds back the next queue pop until its second
//   result is loaded. A four-entry result queue lets the input keep going
//   while the receiver stalls; in_ready drops only when that queue is full.
//   Reset clears the registers, the queue and the output register; no
//   transfer is armed until a configuration write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bit_aligned_copy_shifter #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bacs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [LENGTH_BITS-1:0]         cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     src_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     dst_byte,
    output logic [7:0]                     write_mask,
    output logic                           last
);
    import bacs_pkg::*;

    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    item_t push_item;
    item_t head_item;

    bacs_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .src_byte  (src_byte),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    bacs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    bacs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_item  (head_item),
        .empty      (q_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dst_byte   (dst_byte),
        .write_mask (write_mask),
        .last       (last)
    );

endmodule

`default_nettype wire

// File: rtl/bacs_checker.sv
// ----------------------------------------------------------------------------
// bacs_checker
// Port-level assertions for the copy engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bacs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] dst_byte,
    input logic [7:0] write_mask,
    input logic       last
);

    // Hold a stalled result.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(dst_byte) && $stable(write_mask) && $stable(last), "stalled result changed")

    `ASSERT_CLK(a_mask_nonzero, clk, rst_n, !out_valid || (write_mask != 8'h00), "empty write mask")

    `ASSERT_CLK(a_unmasked_zero, clk, rst_n, !out_valid || ((dst_byte & ~write_mask) == 8'h00), "data outside mask")

    // Any byte before the final one runs to the end of the byte.
    `ASSERT_CLK(a_mid_full_tail, clk, rst_n, !out_valid || last || write_mask[0], "non-final byte clipped at tail")

endmodule

bind bit_aligned_copy_shifter bacs_checker u_bacs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .dst_byte   (dst_byte),
    .write_mask (write_mask),
    .last       (last)
);

`default_nettype wire
